[rtl/sisp_pkg.sv]
package sisp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CharW-1:0] AsciiZero = 8'h30;
  localparam logic [CharW-1:0] AsciiNine = 8'h39;
  localparam logic [CharW-1:0] AsciiSpace = 8'h20;
  localparam logic [CharW-1:0] AsciiTab = 8'h09;
  localparam logic [CharW-1:0] AsciiCr = 8'h0D;
  localparam logic [CharW-1:0] AsciiNul = 8'h00;

  localparam logic [CharW-1:0] KiloReset = 8'd107;
  localparam logic [CharW-1:0] MegaReset = 8'd77;

  localparam logic [35:0] DecMul  = 36'd10;
  localparam logic [41:0] KiloMul = 42'd1000;
  localparam logic [51:0] MegaMul = 52'd1000000;

  localparam logic [LenW-1:0] LenMax = '1;

  localparam logic [CfgIdxW-1:0] CfgKilo = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMega = 1'b1;

  typedef enum logic [2:0] {
    PhSkip   = 3'b001,
    PhDigits = 3'b010,
    PhSuffix = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [ValueW-1:0] accum;
    logic              wrapped;
    logic [LenW-1:0]   consumed;
  } state_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              status;
    logic              overflow;
    logic [LenW-1:0]   length;
  } result_t;

endpackage

[rtl/sisp_if.sv]
interface sisp_in_if;
  logic                       valid;
  logic                       ready;
  logic [sisp_pkg::CharW-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface sisp_out_if;
  logic                        valid;
  logic                        ready;
  logic [sisp_pkg::ValueW-1:0] value;
  logic                        status;
  logic                        overflow;
  logic [sisp_pkg::LenW-1:0]   length;
  modport source (output valid, output value, output status, output overflow,
                  output length, input ready);
  modport sink (input valid, input value, input status, input overflow,
                input length, output ready);
endinterface

interface sisp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sisp_pkg::CfgIdxW-1:0] index;
  logic [sisp_pkg::CharW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/sisp_step.sv]
module sisp_step (
  input  logic [sisp_pkg::CharW-1:0] ch_i,
  input  logic [sisp_pkg::CharW-1:0] kilo_char_i,
  input  logic [sisp_pkg::CharW-1:0] mega_char_i,
  input  sisp_pkg::state_t           state_i,
  output sisp_pkg::state_t           state_o,
  output logic                       emit_o,
  output sisp_pkg::result_t          res_o
);
  import sisp_pkg::*;

  logic            is_blank, is_digit, is_nul, is_zero, is_kilo, is_mega;
  logic [3:0]      digit;
  logic [LenW-1:0] cnt_inc;
  logic [35:0]     dec_full;
  logic [41:0]     kilo_full;
  logic [51:0]     mega_full;
  logic            err;
  state_t          cleared;

  assign is_blank = (ch_i == AsciiSpace) || ((ch_i >= AsciiTab) && (ch_i <= AsciiCr));
  assign is_digit = (ch_i >= AsciiZero) && (ch_i <= AsciiNine);
  assign is_nul   = (ch_i == AsciiNul);
  assign is_zero  = (ch_i == AsciiZero);
  assign is_kilo  = (ch_i == kilo_char_i);
  assign is_mega  = (ch_i == mega_char_i);
  assign digit    = 4'(ch_i - AsciiZero);
  assign cnt_inc  = (state_i.consumed == LenMax) ? state_i.consumed
                                                 : state_i.consumed + 1'b1;

  // constant multiplies, the upper bits flag a wrap
  assign dec_full  = 36'(state_i.accum) * DecMul + 36'(digit);
  assign kilo_full = 42'(state_i.accum) * KiloMul;
  assign mega_full = 52'(state_i.accum) * MegaMul;

  assign cleared = '{phase: PhSkip, accum: '0, wrapped: 1'b0, consumed: '0};

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    err     = 1'b0;
    unique case (state_i.phase)
      PhSuffix: begin
        emit_o = 1'b1;
        err    = !(is_blank || is_nul);
      end
      PhDigits: begin
        if (is_digit) begin
          state_o.accum    = dec_full[ValueW-1:0];
          state_o.wrapped  = state_i.wrapped || (dec_full[35:ValueW] != '0);
          state_o.consumed = cnt_inc;
        end else if (is_blank || is_nul) begin
          emit_o = 1'b1;
        end else if (is_kilo) begin
          state_o.accum    = kilo_full[ValueW-1:0];
          state_o.wrapped  = state_i.wrapped || (kilo_full[41:ValueW] != '0);
          state_o.consumed = cnt_inc;
          state_o.phase    = PhSuffix;
        end else if (is_mega) begin
          state_o.accum    = mega_full[ValueW-1:0];
          state_o.wrapped  = state_i.wrapped || (mega_full[51:ValueW] != '0);
          state_o.consumed = cnt_inc;
          state_o.phase    = PhSuffix;
        end else begin
          emit_o = 1'b1;
          err    = 1'b1;
        end
      end
      default: begin
        // skipping, also any stray phase code
        state_o.phase = PhSkip;
        if (is_blank || is_zero) begin
          state_o.consumed = cnt_inc;
        end else if (is_digit) begin
          state_o.accum    = ValueW'(digit);
          state_o.consumed = cnt_inc;
          state_o.phase    = PhDigits;
        end else if (is_nul) begin
          emit_o = 1'b1;
        end else if (is_kilo) begin
          state_o.accum    = kilo_full[ValueW-1:0];
          state_o.wrapped  = state_i.wrapped || (kilo_full[41:ValueW] != '0);
          state_o.consumed = cnt_inc;
          state_o.phase    = PhSuffix;
        end else if (is_mega) begin
          state_o.accum    = mega_full[ValueW-1:0];
          state_o.wrapped  = state_i.wrapped || (mega_full[51:ValueW] != '0);
          state_o.consumed = cnt_inc;
          state_o.phase    = PhSuffix;
        end else begin
          emit_o = 1'b1;
          err    = 1'b1;
        end
      end
    endcase
    if (emit_o) begin
      state_o = cleared;
    end
  end

  assign res_o.value    = err ? '0 : state_i.accum;
  assign res_o.status   = err;
  assign res_o.overflow = !err && state_i.wrapped;
  assign res_o.length   = err ? '0 : state_i.consumed;

endmodule

[rtl/si_suffix_integer_parser.sv]
// channel | dir | handshake     | payload
// in_i    | in  | valid / ready | ch (8 bit character)
// out_o   | out | valid / ready | value, status, overflow, length
// cfg_i   | in  | valid / ready | index (0 kilo_char, 1 mega_char), data
//
// one character per cycle while the result is not stalled; after the terminating
// character beat, a result passes the input register, then the result register
// each parse state update is computed combinationally by constant multiply-adds
// rst_ni clears the parse state and the result valid flag and restores 'k' and 'M'
// a stalled result holds the input register; cfg_i is always ready
module si_suffix_integer_parser (
  input  logic   clk_i,
  input  logic   rst_ni,
  sisp_in_if.sink     in_i,
  sisp_out_if.source  out_o,
  sisp_cfg_if.sink    cfg_i
);
  import sisp_pkg::*;

  logic [CharW-1:0] ch_q;
  logic             ch_valid_q;
  logic [CharW-1:0] kilo_q, mega_q;
  state_t           state_q, state_d;
  result_t          res_q, res_d;
  logic             out_valid_q;
  logic             emit;
  logic             adv;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !ch_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  sisp_step u_step (
    .ch_i       (ch_q),
    .kilo_char_i(kilo_q),
    .mega_char_i(mega_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .emit_o     (emit),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PhSkip, accum: '0, wrapped: 1'b0, consumed: '0};
      kilo_q      <= KiloReset;
      mega_q      <= MegaReset;
    end else begin
      if (in_i.ready) begin
        ch_valid_q <= in_i.valid;
      end
      if (ch_valid_q && adv) begin
        state_q <= state_d;
      end
      if (adv) begin
        out_valid_q <= ch_valid_q && emit;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CfgKilo: kilo_q <= cfg_i.data;
          CfgMega: mega_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q <= in_i.ch;
    end
    if (ch_valid_q && adv && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.value    = res_q.value;
  assign out_o.status   = res_q.status;
  assign out_o.overflow = res_q.overflow;
  assign out_o.length   = res_q.length;

endmodule

[rtl/sisp_checker.sv]
module sisp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [sisp_pkg::ValueW-1:0]        out_value_i,
  input logic                               out_status_i,
  input logic                               out_overflow_i,
  input logic [sisp_pkg::LenW-1:0]          out_length_i
);
  import sisp_pkg::*;

  // an error beat carries no number
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_value_i == '0 && out_length_i == '0
                                    && !out_overflow_i)
    else $error("error result carries nonzero fields");

  // input side never blocks while the result register is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // a new result follows an input beat through the input and result registers
  a_rose_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a preceding input beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
                                    && $stable(out_length_i))
    else $error("stalled result changed");

endmodule

bind si_suffix_integer_parser sisp_checker u_sisp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.value),
  .out_status_i   (out_o.status),
  .out_overflow_i (out_o.overflow),
  .out_length_i   (out_o.length)
);
